// ===== design/blcs_pkg.sv =====
package blcs_pkg;

  localparam int unsigned INDEX_BITS_DEF   = 16;
  localparam int unsigned DEPTH_BITS_DEF   = 16;
  localparam int unsigned SEARCH_SLOTS_DEF = 4;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned MAX_SLOTS = 4;
  localparam int unsigned KINDS     = 3;

  localparam logic [CHAR_W-1:0] CH_RO = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RC = 8'h29;
  localparam logic [CHAR_W-1:0] CH_SO = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_SC = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_CO = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_CC = 8'h7D;

  localparam logic [CHAR_W-1:0] OPEN_CH  [KINDS] = '{CH_RO, CH_SO, CH_CO};
  localparam logic [CHAR_W-1:0] CLOSE_CH [KINDS] = '{CH_RC, CH_SC, CH_CC};

  localparam logic [CFG_IDX_W-1:0] REG_CHAR_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 3'd5;

  typedef struct packed {
    logic [MAX_SLOTS-1:0][CHAR_W-1:0] chars;
    logic [COUNT_W-1:0]               count;
    logic                             reverse;
  } cfg_t;

endpackage

// ===== design/bracket_level_char_search.sv =====
// Bracket-aware character search over a streamed text.
// Input channel (in_valid/in_ready): one character per transfer, with
// in_scan_start on the first character of a scan (latches in_base_index and
// clears the round, square and curly depths) and in_scan_end on the last one.
// Output channel (out_valid/out_ready): at most one result per scan:
// out_found = 1 with out_match_index for the first search character seen at
// bracket depth zero, or out_found = 0 with index 0 when the scan ends first.
// Configuration (cfg_wr_en/cfg_index/cfg_data): search characters, count of
// slots in use and reverse mode; write only while no scan is in flight.
// Flow: a character transfer loads the input register; the result it yields
// is loaded into the result register when the input register fires.
// Throughput: one character per cycle while the receiver is not stalled, as
// the depth update and set compare are combinational.
// A stalled receiver holds the result register; the input register still takes
// one more character, then in_ready drops until the result is transferred.
// Reset: both registers empty, depths and counters zero, configuration zero,
// scanner idle until a character with in_scan_start arrives.
module bracket_level_char_search #(
  parameter int unsigned INDEX_BITS   = blcs_pkg::INDEX_BITS_DEF,
  parameter int unsigned DEPTH_BITS   = blcs_pkg::DEPTH_BITS_DEF,
  parameter int unsigned SEARCH_SLOTS = blcs_pkg::SEARCH_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [blcs_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                            in_scan_start,
  input  logic                            in_scan_end,
  input  logic [INDEX_BITS-1:0]           in_base_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [INDEX_BITS-1:0]           out_match_index,
  input  logic                            cfg_wr_en,
  input  logic [blcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blcs_pkg::CFG_DATA_W-1:0] cfg_data
);

  blcs_pkg::cfg_t              cfg_r;
  logic                        s1_valid_r;
  logic [blcs_pkg::CHAR_W-1:0] s1_char_r;
  logic                        s1_start_r, s1_end_r;
  logic [INDEX_BITS-1:0]       s1_base_r;
  logic                        s1_fire;
  logic                        res_valid, res_found;
  logic [INDEX_BITS-1:0]       res_index;
  logic                        out_valid_r, out_found_r;
  logic [INDEX_BITS-1:0]       out_index_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        blcs_pkg::REG_CHAR_A:  cfg_r.chars[0] <= cfg_data;
        blcs_pkg::REG_CHAR_B:  cfg_r.chars[1] <= cfg_data;
        blcs_pkg::REG_CHAR_C:  cfg_r.chars[2] <= cfg_data;
        blcs_pkg::REG_CHAR_D:  cfg_r.chars[3] <= cfg_data;
        blcs_pkg::REG_COUNT:   cfg_r.count    <= cfg_data[blcs_pkg::COUNT_W-1:0];
        blcs_pkg::REG_REVERSE: cfg_r.reverse  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r  <= in_char_code;
      s1_start_r <= in_scan_start;
      s1_end_r   <= in_scan_end;
      s1_base_r  <= in_base_index;
    end
  end

  blcs_scan #(
    .INDEX_BITS   (INDEX_BITS),
    .DEPTH_BITS   (DEPTH_BITS),
    .SEARCH_SLOTS (SEARCH_SLOTS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_fire),
    .char_code  (s1_char_r),
    .scan_start (s1_start_r),
    .scan_end   (s1_end_r),
    .base_index (s1_base_r),
    .cfg        (cfg_r),
    .res_valid  (res_valid),
    .res_found  (res_found),
    .res_index  (res_index)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_found_r <= res_found;
      out_index_r <= res_index;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_index_r;

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire))
    else $error("result appeared without a processed character");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both registers are held");

  a_notfound_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_index_r == '0)
    else $error("nonzero index on a miss");

endmodule

// ===== design/blcs_scan.sv =====
module blcs_scan #(
  parameter int unsigned INDEX_BITS   = blcs_pkg::INDEX_BITS_DEF,
  parameter int unsigned DEPTH_BITS   = blcs_pkg::DEPTH_BITS_DEF,
  parameter int unsigned SEARCH_SLOTS = blcs_pkg::SEARCH_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [blcs_pkg::CHAR_W-1:0] char_code,
  input  logic                        scan_start,
  input  logic                        scan_end,
  input  logic [INDEX_BITS-1:0]       base_index,
  input  blcs_pkg::cfg_t              cfg,
  output logic                        res_valid,
  output logic                        res_found,
  output logic [INDEX_BITS-1:0]       res_index
);

  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE = 1;
  localparam logic [INDEX_BITS-1:0]        IDX_ONE   = 1;

  logic signed [DEPTH_BITS-1:0] depth_r   [blcs_pkg::KINDS];
  logic signed [DEPTH_BITS-1:0] depth_nxt [blcs_pkg::KINDS];
  logic signed [DEPTH_BITS-1:0] d_cur     [blcs_pkg::KINDS];
  logic signed [DEPTH_BITS-1:0] d_mid     [blcs_pkg::KINDS];
  logic [INDEX_BITS-1:0]        offset_r, offset_nxt, off_eff;
  logic [INDEX_BITS-1:0]        base_r, base_nxt, base_eff;
  logic                         done_r, done_nxt;
  logic                         active, level_zero, in_set, hit;
  logic [blcs_pkg::CHAR_W-1:0]  opener, closer;

  always_comb begin
    active   = scan_start || !done_r;
    base_eff = scan_start ? base_index : base_r;
    off_eff  = scan_start ? '0 : offset_r;
    level_zero = 1'b1;
    for (int k = 0; k < blcs_pkg::KINDS; k++) begin
      closer = cfg.reverse ? blcs_pkg::OPEN_CH[k] : blcs_pkg::CLOSE_CH[k];
      opener = cfg.reverse ? blcs_pkg::CLOSE_CH[k] : blcs_pkg::OPEN_CH[k];
      d_cur[k] = scan_start ? '0 : depth_r[k];
      d_mid[k] = (char_code == closer && d_cur[k] != DEPTH_MIN) ?
                 d_cur[k] - DEPTH_ONE : d_cur[k];
      depth_nxt[k] = (char_code == opener && d_mid[k] != DEPTH_MAX) ?
                     d_mid[k] + DEPTH_ONE : d_mid[k];
      level_zero = level_zero && (d_mid[k] == '0);
    end
    in_set = 1'b0;
    for (int i = 0; i < SEARCH_SLOTS; i++) begin
      if (blcs_pkg::COUNT_W'(i) < cfg.count && cfg.chars[i] == char_code) begin
        in_set = 1'b1;
      end
    end
    hit        = level_zero && in_set;
    res_valid  = active && (hit || scan_end);
    res_found  = hit;
    res_index  = !hit ? '0 :
                 cfg.reverse ? base_eff - IDX_ONE - off_eff : base_eff + off_eff;
    offset_nxt = off_eff + IDX_ONE;
    base_nxt   = base_eff;
    done_nxt   = hit || scan_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < blcs_pkg::KINDS; k++) begin
        depth_r[k] <= '0;
      end
      offset_r <= '0;
      base_r   <= '0;
      done_r   <= 1'b1;
    end else if (fire && active) begin
      for (int k = 0; k < blcs_pkg::KINDS; k++) begin
        depth_r[k] <= depth_nxt[k];
      end
      offset_r <= offset_nxt;
      base_r   <= base_nxt;
      done_r   <= done_nxt;
    end
  end

  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> done_r)
    else $error("scan not closed after result");

  a_offset_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(offset_r) && $stable(done_r))
    else $error("scan state moved without a transfer");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && done_r && !scan_start |-> !res_valid)
    else $error("result from an idle scanner");

endmodule

// ===== sim/tb_bracket_level_char_search.sv =====
`timescale 1ns / 100ps

module tb_bracket_level_char_search;

  localparam int IW = blcs_pkg::INDEX_BITS_DEF;
  localparam int LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 600;
  localparam int PHASES = 8;
  localparam int SAT_RUN = 1 << (blcs_pkg::DEPTH_BITS_DEF - 1);
  localparam logic [blcs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [blcs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [blcs_pkg::CHAR_W-1:0] COMMA_CH = 8'h2C;
  localparam logic [blcs_pkg::CHAR_W-1:0] BRACKETS [6] = '{
    blcs_pkg::CH_RO, blcs_pkg::CH_RC, blcs_pkg::CH_SO,
    blcs_pkg::CH_SC, blcs_pkg::CH_CO, blcs_pkg::CH_CC};
  localparam int COUNT_PLAN [PHASES] = '{4, 1, 0, 7, 2, 3, 5, 6};

  typedef struct packed {
    logic          found;
    logic [IW-1:0] index;
  } scan_result_t;

  class scan_scoreboard;
    logic [blcs_pkg::CHAR_W-1:0]  slot [blcs_pkg::MAX_SLOTS];
    logic [blcs_pkg::COUNT_W-1:0] count;
    logic                         reverse;
    int                           round_d, square_d, curly_d;
    logic [IW-1:0]                offset, base;
    bit                           done;
    scan_result_t                 pending [$];
    int                           errors;

    function new();
      foreach (slot[i]) slot[i] = '0;
      count = '0;
      reverse = 1'b0;
      round_d = 0;
      square_d = 0;
      curly_d = 0;
      offset = '0;
      base = '0;
      done = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(logic [blcs_pkg::CFG_IDX_W-1:0] idx,
                          logic [blcs_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        blcs_pkg::REG_CHAR_A: slot[0] = data;
        blcs_pkg::REG_CHAR_B: slot[1] = data;
        blcs_pkg::REG_CHAR_C: slot[2] = data;
        blcs_pkg::REG_CHAR_D: slot[3] = data;
        blcs_pkg::REG_COUNT: count = data[blcs_pkg::COUNT_W-1:0];
        blcs_pkg::REG_REVERSE: reverse = data[0];
        default: ;
      endcase
    endfunction

    function int sat_depth(int d, int delta);
      int hi, lo, r;
      hi = SAT_RUN - 1;
      lo = -hi - 1;
      r = d + delta;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r;
    endfunction

    function bit in_search_set(logic [blcs_pkg::CHAR_W-1:0] c);
      int n;
      n = (count > blcs_pkg::SEARCH_SLOTS_DEF) ? blcs_pkg::SEARCH_SLOTS_DEF : count;
      for (int i = 0; i < n; i++)
        if (slot[i] == c) return 1'b1;
      return 1'b0;
    endfunction

    // returns 1 when the character is taken into a scan
    function bit note_char(logic [blcs_pkg::CHAR_W-1:0] c, logic s, logic e,
                           logic [IW-1:0] b);
      logic [blcs_pkg::CHAR_W-1:0] r_open, r_close, s_open, s_close, c_open, c_close;
      scan_result_t res;
      r_open = reverse ? blcs_pkg::CH_RC : blcs_pkg::CH_RO;
      r_close = reverse ? blcs_pkg::CH_RO : blcs_pkg::CH_RC;
      s_open = reverse ? blcs_pkg::CH_SC : blcs_pkg::CH_SO;
      s_close = reverse ? blcs_pkg::CH_SO : blcs_pkg::CH_SC;
      c_open = reverse ? blcs_pkg::CH_CC : blcs_pkg::CH_CO;
      c_close = reverse ? blcs_pkg::CH_CO : blcs_pkg::CH_CC;
      if (s) begin
        round_d = 0;
        square_d = 0;
        curly_d = 0;
        offset = '0;
        base = b;
        done = 1'b0;
      end else if (done) begin
        return 1'b0;
      end
      if (c == r_close) round_d = sat_depth(round_d, -1);
      else if (c == s_close) square_d = sat_depth(square_d, -1);
      else if (c == c_close) curly_d = sat_depth(curly_d, -1);
      if (round_d == 0 && square_d == 0 && curly_d == 0 && in_search_set(c)) begin
        res.found = 1'b1;
        res.index = reverse ? base - IW'(1) - offset : base + offset;
        pending.insert(pending.size(), res);
        done = 1'b1;
        return 1'b1;
      end
      if (c == r_open) round_d = sat_depth(round_d, 1);
      else if (c == s_open) square_d = sat_depth(square_d, 1);
      else if (c == c_open) curly_d = sat_depth(curly_d, 1);
      if (e) begin
        res.found = 1'b0;
        res.index = '0;
        pending.insert(pending.size(), res);
        done = 1'b1;
        return 1'b1;
      end
      offset = offset + IW'(1);
      return 1'b1;
    endfunction

    function void check_result(logic found, logic [IW-1:0] index);
      scan_result_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result: found %0d, match_index %0d", found, index);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (found !== exp_res.found) begin
        $error("found: expected %0d, actual %0d", exp_res.found, found);
        errors++;
      end
      if (index !== exp_res.index) begin
        $error("match_index: expected %0d, actual %0d", exp_res.index, index);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [blcs_pkg::CHAR_W-1:0]     in_char_code;
  logic                            in_scan_start;
  logic                            in_scan_end;
  logic [IW-1:0]                   in_base_index;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_found;
  logic [IW-1:0]                   out_match_index;
  logic                            cfg_wr_en;
  logic [blcs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [blcs_pkg::CFG_DATA_W-1:0] cfg_data;

  scan_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent_chars = 0;
  int cycles = 0;

  bracket_level_char_search DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_scan_start  (in_scan_start),
    .in_scan_end    (in_scan_end),
    .in_base_index  (in_base_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_match_index(out_match_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_found, out_match_index);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [blcs_pkg::CHAR_W-1:0] stim_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return BRACKETS[$urandom_range(5)];
    if (r < 65) return sb.slot[$urandom_range(blcs_pkg::MAX_SLOTS - 1)];
    return blcs_pkg::CHAR_W'($urandom);
  endfunction

  function automatic logic [blcs_pkg::CHAR_W-1:0] cfg_char();
    case ($urandom_range(3))
      0: return BRACKETS[$urandom_range(5)];
      1: return blcs_pkg::CHAR_W'($urandom);
      default: return blcs_pkg::CHAR_W'($urandom_range(8'h7E, 8'h20));
    endcase
  endfunction

  function automatic logic [IW-1:0] pick_base();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return IW'(16'hFFFF - $urandom_range(8));
      default: return IW'($urandom);
    endcase
  endfunction

  task automatic send_char(logic [blcs_pkg::CHAR_W-1:0] c, logic s, logic e,
                           logic [IW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_scan_start <= s;
    in_scan_end <= e;
    in_base_index <= b;
    do @(posedge clk); while (!in_ready);
    void'(sb.note_char(c, s, e, b));
    sent_chars++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [blcs_pkg::CFG_IDX_W-1:0] idx,
                           logic [blcs_pkg::CFG_DATA_W-1:0] data, bit last);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    if (last) cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int len;
    int goal;
    logic [IW-1:0] base;
    logic s, e;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_code <= '0;
    in_scan_start <= 1'b0;
    in_scan_end <= 1'b0;
    in_base_index <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 16;
    stall_pct = 16;
    write_reg(blcs_pkg::REG_CHAR_A, 8'h00, 1'b0);
    write_reg(blcs_pkg::REG_CHAR_B, 8'hFF, 1'b0);
    write_reg(blcs_pkg::REG_CHAR_C, COMMA_CH, 1'b0);
    write_reg(blcs_pkg::REG_CHAR_D, blcs_pkg::CH_RC, 1'b0);
    write_reg(blcs_pkg::REG_COUNT, 8'h04, 1'b0);
    write_reg(blcs_pkg::REG_REVERSE, 8'h00, 1'b0);
    write_reg(REG_SPARE_LO, blcs_pkg::CFG_DATA_W'($urandom), 1'b0);
    write_reg(REG_SPARE_HI, blcs_pkg::CFG_DATA_W'($urandom), 1'b1);

    send_char(8'h00, 1'b1, 1'b1, 16'h0000);
    // closer drops to level zero before the set test
    send_char(blcs_pkg::CH_RO, 1'b1, 1'b0, 16'd100);
    send_char(COMMA_CH, 1'b0, 1'b0, 16'h0000);
    send_char(blcs_pkg::CH_RC, 1'b0, 1'b1, 16'h0000);
    send_char(COMMA_CH, 1'b0, 1'b0, 16'h1234);
    send_char(blcs_pkg::CH_SO, 1'b1, 1'b0, 16'd7);
    send_char(blcs_pkg::CH_CO, 1'b0, 1'b0, 16'h0000);
    send_char(8'hFF, 1'b0, 1'b1, 16'h0000);
    send_char(blcs_pkg::CH_SC, 1'b1, 1'b0, 16'd9);
    send_char(COMMA_CH, 1'b0, 1'b1, 16'h0000);
    send_char(COMMA_CH, 1'b1, 1'b1, 16'hFFFF);
    send_char(blcs_pkg::CH_RO, 1'b1, 1'b0, 16'd3);
    send_char(COMMA_CH, 1'b1, 1'b0, 16'd5);
    send_char(8'h61, 1'b1, 1'b0, 16'hFFFE);
    send_char(8'h62, 1'b0, 1'b0, 16'h0000);
    send_char(8'hFF, 1'b0, 1'b0, 16'h0000);
    send_char(blcs_pkg::CH_CO, 1'b1, 1'b0, 16'd1);
    send_char(blcs_pkg::CH_CC, 1'b0, 1'b0, 16'h0000);
    send_char(8'h71, 1'b0, 1'b1, 16'h0000);

    settle();
    write_reg(blcs_pkg::REG_CHAR_A, blcs_pkg::CH_RO, 1'b0);
    write_reg(blcs_pkg::REG_CHAR_B, 8'h00, 1'b0);
    write_reg(blcs_pkg::REG_COUNT, 8'hF9, 1'b0);
    write_reg(blcs_pkg::REG_REVERSE, 8'hFF, 1'b1);
    send_char(blcs_pkg::CH_RC, 1'b1, 1'b0, 16'h0000);
    send_char(8'h79, 1'b0, 1'b0, 16'h0000);
    send_char(blcs_pkg::CH_RO, 1'b0, 1'b1, 16'h0000);
    send_char(blcs_pkg::CH_RO, 1'b1, 1'b1, 16'd10);
    settle();
    write_reg(blcs_pkg::REG_COUNT, 8'h00, 1'b1);
    send_char(8'h00, 1'b1, 1'b1, 16'd20);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 67; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 67; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      write_reg(blcs_pkg::REG_CHAR_A, (p == 0) ? 8'h00 : cfg_char(), 1'b0);
      write_reg(blcs_pkg::REG_CHAR_B, cfg_char(), 1'b0);
      write_reg(blcs_pkg::REG_CHAR_C, cfg_char(), 1'b0);
      write_reg(blcs_pkg::REG_CHAR_D, (p == PHASES - 1) ? 8'hFF : cfg_char(), 1'b0);
      write_reg(blcs_pkg::REG_COUNT,
                {5'($urandom_range(31)), 3'(COUNT_PLAN[p])}, 1'b0);
      write_reg(blcs_pkg::REG_REVERSE, {7'($urandom_range(127)), 1'(p % 2)}, 1'b1);
      goal = sent_chars + RANDOM_ITEMS / PHASES;
      while (sent_chars < goal) begin
        len = $urandom_range(1, 12);
        base = pick_base();
        for (int i = 0; i < len; i++) begin
          s = (i == 0);
          e = (i == len - 1);
          if ($urandom_range(99) < 4) s = ~s;
          if ($urandom_range(99) < 4) e = ~e;
          send_char(stim_char(), s, e, s ? base : IW'($urandom));
        end
        if ($urandom_range(99) < 3) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
